>>> hw/rtl/rdq_pkg.sv
// Package for the reversible deque: operation and status codes, default depth,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package rdq_pkg;

    // Default number of ring slots
    localparam int DEPTH_DEF = 1024;

    // Field widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REVERSE    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_VALUE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic                push;      // write value into the ring
        logic                pop;       // read an entry and remove it
        logic                at_head;   // act on the physical head (else tail)
        logic                toggle;    // flip the reverse flag
        logic                load_now;  // load result register with status, popped 0
        logic                load_mem;  // load result register from RAM read data
        logic [STATUS_W-1:0] status;    // status for load_now
    } rdq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic reversed;
    } rdq_stat_t;

endpackage

>>> hw/rtl/rdq_in_if.sv
// Input channel interface: valid/ready handshake carrying opcode and value.
// Depends on rdq_pkg.
`timescale 1ns / 1ps

interface rdq_in_if;
    import rdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> hw/rtl/rdq_out_if.sv
// Output channel interface: valid/ready handshake carrying popped value and status.
// Depends on rdq_pkg.
`timescale 1ns / 1ps

interface rdq_out_if;
    import rdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  popped;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output popped, output status, input ready);
    modport sink   (input valid, input popped, input status, output ready);
endinterface

>>> hw/rtl/rdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rdq_ctrl.sv
// Controller: handshake state machine and opcode decode for the deque.
// Depends on rdq_pkg; drives the datapath through rdq_cmd_t.
`timescale 1ns / 1ps

module rdq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rdq_pkg::OPCODE_W-1:0]  opcode,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  rdq_pkg::rdq_stat_t            stat,
    output rdq_pkg::rdq_cmd_t             cmd
);
    import rdq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic     state_reg;
    logic     state_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     accept;

    // Take a new transaction only when idle and the result slot is free
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Decode and next state
    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode) inside
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            cmd.load_now = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push    = 1'b1;
                                // tail when (opcode == OP_PUSH_BACK) differs from the flag
                                cmd.at_head = ((opcode == OP_PUSH_BACK) == stat.reversed);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_now = 1'b1;
                                cmd.status   = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop     = 1'b1;
                                cmd.at_head = ((opcode == OP_POP_FRONT) != stat.reversed);
                                state_next  = S_READ;
                            end
                        end
                        OP_REVERSE:
                        begin
                            cmd.toggle   = 1'b1;
                            cmd.load_now = 1'b1;
                        end
                        default:
                        begin
                            cmd.load_now = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.load_mem = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        if (cmd.load_now || cmd.load_mem)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/rdq_dpath.sv
// Datapath: ring pointers, occupancy, reverse flag, storage RAM and result register.
// Depends on rdq_pkg and rdq_ram.
`timescale 1ns / 1ps

module rdq_dpath #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdq_pkg::rdq_cmd_t                   cmd,
    output rdq_pkg::rdq_stat_t                  stat,
    input  logic signed [rdq_pkg::VALUE_W-1:0]  value,
    output logic signed [rdq_pkg::VALUE_W-1:0]  popped,
    output logic [rdq_pkg::STATUS_W-1:0]        status
);
    import rdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0]        first_reg;
    logic [AW-1:0]        first_next;
    logic [CW-1:0]        occ_reg;
    logic [CW-1:0]        occ_next;
    logic                 rev_reg;
    logic [VALUE_W-1:0]   popped_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [AW-1:0]        first_dec;
    logic [AW-1:0]        first_inc;
    logic [SW-1:0]        tail_sum;
    logic [SW-1:0]        last_sum;
    logic [AW-1:0]        tail_idx;
    logic [AW-1:0]        last_idx;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [VALUE_W-1:0]   rdata;

    // Ring index arithmetic
    assign first_dec = (first_reg == '0) ? AW'(DEPTH - 1) : first_reg - AW'(1);
    assign first_inc = (first_reg == AW'(DEPTH - 1)) ? '0 : first_reg + AW'(1);
    assign tail_sum  = SW'(first_reg) + SW'(occ_reg);
    assign last_sum  = tail_sum - SW'(1);
    assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
    assign last_idx  = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

    assign waddr = cmd.at_head ? first_dec : tail_idx;
    assign raddr = cmd.at_head ? first_reg : last_idx;

    assign stat.full     = (occ_reg == CW'(DEPTH));
    assign stat.empty    = (occ_reg == '0);
    assign stat.reversed = rev_reg;

    // Storage
    rdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Pointer and count updates
    always_comb
    begin
        first_next = first_reg;
        occ_next   = occ_reg;
        if (cmd.push)
        begin
            occ_next = occ_reg + CW'(1);
            if (cmd.at_head)
            begin
                first_next = first_dec;
            end
        end
        else if (cmd.pop)
        begin
            occ_next = occ_reg - CW'(1);
            if (cmd.at_head)
            begin
                first_next = first_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            occ_reg   <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            occ_reg   <= occ_next;
            if (cmd.toggle)
            begin
                rev_reg <= ~rev_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_mem)
        begin
            popped_reg <= rdata;
            status_reg <= ST_VALUE;
        end
        else if (cmd.load_now)
        begin
            popped_reg <= '0;
            status_reg <= cmd.status;
        end
    end

    assign popped = popped_reg;
    assign status = status_reg;

endmodule

>>> hw/rtl/reversible_deque.sv
// Reversible deque top level: controller plus datapath.
// Depends on rdq_pkg, rdq_in_if, rdq_out_if, rdq_ctrl, rdq_dpath.
//
// Usage:
//   in_ch carries one operation per transaction (opcode, value); out_ch returns
//   exactly one result (popped, status) per operation, in order.
//   Pushes, refused pushes, empty pops, reverse and unused opcodes: the result
//   is valid the cycle after acceptance.
//   Successful pops: the controller goes through S_READ for the registered RAM
//   read, then loads the result register; in_ch is not ready during that read.
//   Throughput: one operation per cycle for non-popping operations while out_ch
//   takes each result; a successful pop holds off the next operation until its
//   registered RAM read is done. The result register lets the next transaction
//   enter in the same cycle the waiting result is taken; while out_ch stalls
//   with a result held, in_ch is not ready.
//   Reset (rst_n low, asynchronous) empties the deque and clears the reverse
//   flag; no clearing pass is needed, stored values are never read before
//   they are written.
`timescale 1ns / 1ps

module reversible_deque #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rdq_in_if.sink    in_ch,
    rdq_out_if.source out_ch
);
    import rdq_pkg::*;

    rdq_cmd_t  cmd;
    rdq_stat_t stat;

    rdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .opcode    (in_ch.opcode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .value  (in_ch.value),
        .popped (out_ch.popped),
        .status (out_ch.status)
    );

endmodule

>>> tb/tb_reversible_deque.sv
// Self-checking testbench for reversible_deque: directed table, then random phases.
// Depends on rdq_pkg, rdq_in_if, rdq_out_if and the reversible_deque RTL.
`timescale 1ns / 1ps

module tb_reversible_deque;
    import rdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int DIR_N = 26;

    // Opcodes the block ignores
    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
    } deq_result_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  val;
        logic                fixed;
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
    } dir_row_t;

    logic clk;
    logic rst_n;

    rdq_in_if  in_ch ();
    rdq_out_if out_ch ();

    reversible_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // Shadow deque
    logic [VALUE_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]   head;
    logic [IDX_W:0]     fill;
    logic               flipped;

    deq_result_t pending_q [$];
    int          n_errors;
    int          n_ops;
    int          n_popped;
    int          n_refused;
    int          n_empty;
    bit          reached_full;
    bit          gaps_on;

    dir_row_t dir_tab [DIR_N];

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // One operation applied to the shadow deque
    function automatic deq_result_t apply_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val);
        deq_result_t      res;
        logic [IDX_W-1:0] slot;
        res.popped = '0;
        res.status = ST_DONE;
        n_ops++;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)
        begin
            if (fill == DEPTH)
            begin
                res.status = ST_FULL;
                n_refused++;
            end
            else if ((op == OP_PUSH_BACK) ^ flipped)
            begin
                slot = head + fill[IDX_W-1:0];
                ring[slot] = val;
                fill++;
            end
            else
            begin
                head = head - 1'b1;
                ring[head] = val;
                fill++;
            end
            if (fill == DEPTH)
                reached_full = 1'b1;
        end
        else if (op == OP_POP_FRONT || op == OP_POP_BACK)
        begin
            if (fill == 0)
            begin
                res.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                if ((op == OP_POP_FRONT) ^ flipped)
                begin
                    res.popped = ring[head];
                    head = head + 1'b1;
                end
                else
                begin
                    slot = head + fill[IDX_W-1:0] - 1'b1;
                    res.popped = ring[slot];
                end
                fill--;
                res.status = ST_VALUE;
                n_popped++;
            end
        end
        else if (op == OP_REVERSE)
            flipped = ~flipped;
        return res;
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        else if ($urandom_range(0, 2) != 0)
            return OP_REVERSE;
        else
            return OP_SPARE_FIRST + OPCODE_W'($urandom_range(0, 2));
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
        $display("tb: mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    // Drive one transaction, then record its expected result
    task automatic send_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
                           bit use_fixed, deq_result_t fixed_res);
        deq_result_t res;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= val;
        do @(posedge clk); while (!in_ch.ready);
        res = apply_op(op, val);
        pending_q.insert(pending_q.size(), use_fixed ? fixed_res : res);
        @(negedge clk);
    endtask

    task automatic send_rand(int push_pct, int pop_pct);
        send_op(pick_op(push_pct, pop_pct), $urandom, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stall bursts
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (gaps_on && stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected result, popped", out_ch.popped, '0);
            else
            begin
                want = pending_q.pop_front();
                if (out_ch.popped !== want.popped)
                    report_mismatch("popped", out_ch.popped, want.popped);
                if (out_ch.status !== want.status)
                    report_mismatch("status", VALUE_W'(out_ch.status), VALUE_W'(want.status));
            end
        end
    end

    // Stimulus
    initial
    begin
        deq_result_t fixed_res;
        int          extra;

        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_PUSH_BACK;
        in_ch.value  = '0;
        rst_n        = 1'b0;
        head         = '0;
        fill         = '0;
        flipped      = 1'b0;
        n_errors     = 0;
        n_ops        = 0;
        n_popped     = 0;
        n_refused    = 0;
        n_empty      = 0;
        reached_full = 1'b0;
        gaps_on      = 1'b1;

        // Empty corners, reversed ends, spare opcodes, value extremes, front-first push
        dir_tab = '{
            '{OP_POP_FRONT,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
            '{OP_POP_BACK,    32'hFFFF_FFFF, 1'b1, 32'h0, ST_EMPTY},
            '{OP_REVERSE,     32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
            '{OP_PUSH_BACK,   32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_REVERSE,     32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_SPARE_FIRST, 32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_SPARE_MID,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_DONE},
            '{OP_SPARE_LAST,  32'h8000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_BACK,   32'h7FFF_FFFF, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_BACK,   32'h8000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_FRONT,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_FRONT,  32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_POP_FRONT,   32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_REVERSE,     32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_BACK,   32'h1234_5678, 1'b1, 32'h0, ST_DONE},
            '{OP_POP_FRONT,   32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_POP_FRONT,   32'h0000_0000, 1'b1, 32'h0, ST_EMPTY},
            '{OP_REVERSE,     32'h0000_0000, 1'b1, 32'h0, ST_DONE},
            '{OP_PUSH_FRONT,  32'h5555_5555, 1'b1, 32'h0, ST_DONE},
            '{OP_POP_BACK,    32'h0000_0000, 1'b0, 32'h0, ST_VALUE},
            '{OP_PUSH_BACK,   32'hAAAA_AAAA, 1'b1, 32'h0, ST_DONE}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            fixed_res.popped = dir_tab[i].popped;
            fixed_res.status = dir_tab[i].status;
            send_op(dir_tab[i].op, dir_tab[i].val, dir_tab[i].fixed, fixed_res);
        end

        // Hold off until every result is back
        in_ch.valid <= 1'b0;
        wait_drained();
        @(negedge clk);

        // Balanced mix
        for (int i = 0; i < 300; i++)
            send_rand(45, 45);

        // Fill to full, the first stretch without idling, then some refused pushes
        gaps_on = 1'b0;
        extra   = 0;
        while (fill < DEPTH)
        begin
            if (extra++ == 300)
                gaps_on = 1'b1;
            send_rand(92, 4);
        end
        gaps_on = 1'b1;
        for (int i = 0; i < 12; i++)
            send_rand(90, 4);

        // Partial drain
        for (int i = 0; i < 300; i++)
            send_rand(8, 88);

        // Closing mix with no idling
        gaps_on = 1'b0;
        for (int i = 0; i < 200; i++)
            send_rand(45, 45);

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);

        $display("tb: %0d operations, %0d values popped, %0d refused pushes, %0d empty pops",
                 n_ops, n_popped, n_refused, n_empty);
        $display("tb: deque filled to capacity: %0s, final occupancy %0d",
                 reached_full ? "yes" : "no", fill);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
